// ===== src/linear_run_to_hyperslab_splitter_defines.svh =====
// Assertion helpers shared by the splitter RTL.
`ifndef LINEAR_RUN_TO_HYPERSLAB_SPLITTER_DEFINES_SVH
`define LINEAR_RUN_TO_HYPERSLAB_SPLITTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LRHS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lrhs same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LRHS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lrhs next-cycle check failed");

`endif

// ===== src/lrhs_pkg.sv =====
package lrhs_pkg;

  localparam int NDIM      = 4;
  localparam int MAX_RANK  = 4;
  localparam int OFF_W     = 48;
  localparam int CRD_W     = 32;
  localparam int EB_W      = 16;
  localparam int RANK_W    = 3;
  localparam int IDX_W     = $clog2(NDIM);
  localparam int STEP_W    = $clog2(OFF_W);
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_RANK = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ELEM = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_DIM0 = CFG_IDX_W'(2);

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } arith_op_t;

  typedef struct packed {
    logic [NDIM-1:0][CRD_W-1:0] start;
    logic [NDIM-1:0][CRD_W-1:0] size;
    logic [OFF_W-1:0]           off;
  } blk_t;

  function automatic logic [CRD_W-1:0] sat32(input logic [OFF_W-1:0] v);
    return (|v[OFF_W-1:CRD_W]) ? '1 : v[CRD_W-1:0];
  endfunction

endpackage

// ===== src/lrhs_arith.sv =====
module lrhs_arith
  import lrhs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  arith_op_t        op,
  input  logic [OFF_W-1:0] opa,
  input  logic [OFF_W-1:0] opb,
  output logic             done,
  output logic [OFF_W-1:0] quot,
  output logic [OFF_W-1:0] acc,
  output logic             ovf
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  arith_op_t         op_r;
  logic [OFF_W-1:0]  a_r;
  logic [OFF_W-1:0]  b_r;
  logic [OFF_W-1:0]  acc_r;
  logic              ovf_r;

  logic [OFF_W:0]    rem_sh;
  logic [OFF_W:0]    dbl;
  logic [OFF_W+1:0]  add_x;
  logic [OFF_W+1:0]  add_y;
  logic [OFF_W+1:0]  sum;
  logic [OFF_W-1:0]  a_nxt;
  logic [OFF_W-1:0]  acc_nxt;
  logic              ovf_nxt;

  // One shared adder: restoring subtract for divide, shift-add for multiply.
  // Both walk the bits of operand a from the top, one bit per cycle.
  always_comb begin
    rem_sh = {acc_r, a_r[OFF_W-1]};
    dbl    = {acc_r, 1'b0};
    if (op_r == OP_DIV) begin
      add_x = {1'b0, rem_sh};
      add_y = ~{2'b00, b_r};
    end else begin
      add_x = {1'b0, dbl};
      add_y = a_r[OFF_W-1] ? {2'b00, b_r} : '0;
    end
    sum     = add_x + add_y + {{(OFF_W+1){1'b0}}, op_r == OP_DIV};
    ovf_nxt = ovf_r;
    if (op_r == OP_DIV) begin
      if (!sum[OFF_W+1]) begin
        acc_nxt = sum[OFF_W-1:0];
        a_nxt   = {a_r[OFF_W-2:0], 1'b1};
      end else begin
        acc_nxt = rem_sh[OFF_W-1:0];
        a_nxt   = {a_r[OFF_W-2:0], 1'b0};
      end
    end else begin
      acc_nxt = sum[OFF_W-1:0];
      a_nxt   = {a_r[OFF_W-2:0], 1'b0};
      ovf_nxt = ovf_r | (|sum[OFF_W+1:OFF_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        cnt_r <= cnt_r + STEP_W'(1);
        if (cnt_r == STEP_W'(OFF_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      a_r   <= a_nxt;
      acc_r <= acc_nxt;
      ovf_r <= ovf_nxt;
    end else if (start) begin
      op_r  <= op;
      a_r   <= opa;
      b_r   <= opb;
      acc_r <= '0;
      ovf_r <= 1'b0;
    end
  end

  assign done = done_r;
  assign quot = a_r;
  assign acc  = acc_r;
  assign ovf  = ovf_r;

endmodule

// ===== src/linear_run_to_hyperslab_splitter.sv =====
// Splits one linear byte run into rectangular blocks of a row-major array.
// Each request runs alone through a small sequencer around one 48-bit shared
// multiply/divide unit that resolves one bit per cycle. A request needs two
// scale divisions, rank - 1 stride multiplies, rank coordinate divisions and
// three steps per emitted block except the final row piece, which needs none,
// besides checks and carries; in_ready is low while the request runs. Up to seven
// blocks come out per request, the last one flagged by out_last_piece.
// Blocks leave through an output register plus one holding stage, so a
// stalled consumer stops the sequencer only when both are full.
`include "linear_run_to_hyperslab_splitter_defines.svh"

module linear_run_to_hyperslab_splitter
  import lrhs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OFF_W-1:0]     in_byte_offset,
  input  logic [OFF_W-1:0]     in_byte_length,
  input  logic                 in_last_sequence,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CRD_W-1:0]     out_start_0,
  output logic [CRD_W-1:0]     out_start_1,
  output logic [CRD_W-1:0]     out_start_2,
  output logic [CRD_W-1:0]     out_start_3,
  output logic [CRD_W-1:0]     out_size_0,
  output logic [CRD_W-1:0]     out_size_1,
  output logic [CRD_W-1:0]     out_size_2,
  output logic [CRD_W-1:0]     out_size_3,
  output logic [OFF_W-1:0]     out_buffer_offset,
  output logic                 out_last_piece,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CRD_W-1:0]     cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE, S_LEN_DIV, S_ADR_DIV, S_DOWN, S_DEC, S_LEAD_CHK, S_LEAD_DIV,
    S_BS_MUL, S_EMIT, S_OFF_MUL, S_CARRY, S_FULL_CHK, S_FULL_DIV,
    S_TRAIL_CHK, S_TRAIL_DIV, S_FINAL, S_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    PH_LEAD, PH_FULL, PH_TRAIL, PH_FINAL
  } phase_t;

  // Configuration.
  logic [RANK_W-1:0] rank_r;
  logic [EB_W-1:0]   eb_r;
  logic [CRD_W-1:0]  dim_r [NDIM];

  logic [RANK_W-1:0] r_eff;
  logic [IDX_W-1:0]  rm1;
  logic [EB_W-1:0]   eb_eff;
  logic [CRD_W-1:0]  dims_eff [NDIM];

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             issued_r, issued_nxt;

  logic [OFF_W-1:0] off_in_r, off_in_nxt;
  logic [OFF_W-1:0] blen_r, blen_nxt;
  logic             lastseq_r, lastseq_nxt;
  logic [OFF_W-1:0] len_r, len_nxt;
  logic [OFF_W-1:0] addr_r, addr_nxt;
  logic [OFF_W-1:0] sz_r, sz_nxt;
  logic [OFF_W-1:0] bs_r, bs_nxt;
  logic [OFF_W-1:0] boff_r, boff_nxt;
  logic [OFF_W-1:0] run_off_r, run_off_nxt;
  logic [OFF_W-1:0] down_r [NDIM];
  logic [OFF_W-1:0] down_nxt [NDIM];
  logic             dsat_r [NDIM];
  logic             dsat_nxt [NDIM];
  logic [OFF_W-1:0] c_r [NDIM];
  logic [OFF_W-1:0] c_nxt [NDIM];

  logic pend_valid_r, pend_valid_nxt;
  blk_t pend_r, pend_nxt;
  logic out_valid_r, out_valid_nxt;
  blk_t out_blk_r, out_blk_nxt;
  logic out_last_r, out_last_nxt;

  blk_t blk_w;
  logic out_free;

  logic             ar_start;
  arith_op_t        ar_op;
  logic [OFF_W-1:0] ar_a;
  logic [OFF_W-1:0] ar_b;
  logic             ar_done;
  logic [OFF_W-1:0] ar_quot;
  logic [OFF_W-1:0] ar_acc;
  logic             ar_ovf;

  lrhs_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ar_start),
    .op    (ar_op),
    .opa   (ar_a),
    .opb   (ar_b),
    .done  (ar_done),
    .quot  (ar_quot),
    .acc   (ar_acc),
    .ovf   (ar_ovf)
  );

  // A register holding zero acts as one; rank is clamped to the supported range.
  always_comb begin
    if (rank_r == '0) begin
      r_eff = RANK_W'(1);
    end else if (rank_r > RANK_W'(MAX_RANK)) begin
      r_eff = RANK_W'(MAX_RANK);
    end else begin
      r_eff = rank_r;
    end
    rm1    = IDX_W'(r_eff - RANK_W'(1));
    eb_eff = (eb_r == '0) ? EB_W'(1) : eb_r;
    for (int j = 0; j < NDIM; j++) begin
      dims_eff[j] = (dim_r[j] == '0) ? CRD_W'(1) : dim_r[j];
    end
  end

  // Block record: below idx the extent is one, at idx it is sz_r and above
  // it the full dimension. This one rule covers every kind of block.
  always_comb begin
    for (int j = 0; j < NDIM; j++) begin
      if (RANK_W'(j) < r_eff) begin
        blk_w.start[j] = sat32(c_r[j]);
        if (IDX_W'(j) < idx_r) begin
          blk_w.size[j] = CRD_W'(1);
        end else if (IDX_W'(j) == idx_r) begin
          blk_w.size[j] = sat32(sz_r);
        end else begin
          blk_w.size[j] = dims_eff[j];
        end
      end else begin
        blk_w.start[j] = '0;
        blk_w.size[j]  = CRD_W'(1);
      end
    end
    blk_w.off = boff_r;
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    logic [CRD_W-1:0] room;
    logic [IDX_W-1:0] idx_p1;
    logic [IDX_W-1:0] idx_m1;
    logic [IDX_W-1:0] idx_m2;

    idx_p1 = idx_r + IDX_W'(1);
    idx_m1 = idx_r - IDX_W'(1);
    idx_m2 = idx_r - IDX_W'(2);
    room   = dims_eff[idx_r] - c_r[idx_r][CRD_W-1:0];

    state_nxt      = state_r;
    phase_nxt      = phase_r;
    idx_nxt        = idx_r;
    issued_nxt     = issued_r;
    off_in_nxt     = off_in_r;
    blen_nxt       = blen_r;
    lastseq_nxt    = lastseq_r;
    len_nxt        = len_r;
    addr_nxt       = addr_r;
    sz_nxt         = sz_r;
    bs_nxt         = bs_r;
    boff_nxt       = boff_r;
    run_off_nxt    = run_off_r;
    down_nxt       = down_r;
    dsat_nxt       = dsat_r;
    c_nxt          = c_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_blk_nxt    = out_blk_r;
    out_last_nxt   = out_last_r;
    ar_start       = 1'b0;
    ar_op          = OP_DIV;
    ar_a           = '0;
    ar_b           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          off_in_nxt  = in_byte_offset;
          blen_nxt    = in_byte_length;
          lastseq_nxt = in_last_sequence;
          boff_nxt    = run_off_r;
          issued_nxt  = 1'b0;
          for (int j = 0; j < NDIM; j++) begin
            down_nxt[j] = OFF_W'(1);
            dsat_nxt[j] = 1'b0;
            c_nxt[j]    = '0;
          end
          state_nxt = S_LEN_DIV;
        end
      end
      S_LEN_DIV: begin
        ar_op      = OP_DIV;
        ar_a       = blen_r;
        ar_b       = OFF_W'(eb_eff);
        ar_start   = !issued_r;
        issued_nxt = 1'b1;
        if (ar_done) begin
          issued_nxt = 1'b0;
          len_nxt    = ar_quot;
          state_nxt  = S_ADR_DIV;
        end
      end
      S_ADR_DIV: begin
        ar_op      = OP_DIV;
        ar_a       = off_in_r;
        ar_b       = OFF_W'(eb_eff);
        ar_start   = !issued_r;
        issued_nxt = 1'b1;
        if (ar_done) begin
          issued_nxt = 1'b0;
          addr_nxt   = ar_quot;
          if (rm1 == '0) begin
            idx_nxt   = '0;
            state_nxt = S_DEC;
          end else begin
            idx_nxt   = rm1 - IDX_W'(1);
            state_nxt = S_DOWN;
          end
        end
      end
      S_DOWN: begin
        // Element stride of dimension idx; anything past 48 bits is only
        // kept as a saturation flag, since no run can reach it.
        ar_op      = OP_MUL;
        ar_a       = down_r[idx_p1];
        ar_b       = OFF_W'(dims_eff[idx_p1]);
        ar_start   = !issued_r;
        issued_nxt = 1'b1;
        if (ar_done) begin
          issued_nxt        = 1'b0;
          down_nxt[idx_r]   = ar_acc;
          dsat_nxt[idx_r]   = ar_ovf || dsat_r[idx_p1];
          if (idx_r == '0) begin
            idx_nxt   = rm1;
            state_nxt = S_DEC;
          end else begin
            idx_nxt = idx_m1;
          end
        end
      end
      S_DEC: begin
        ar_op      = OP_DIV;
        ar_a       = addr_r;
        ar_b       = OFF_W'(dims_eff[idx_r]);
        ar_start   = !issued_r;
        issued_nxt = 1'b1;
        if (ar_done) begin
          issued_nxt    = 1'b0;
          c_nxt[idx_r]  = ar_acc;
          addr_nxt      = ar_quot;
          if (idx_r == '0) begin
            idx_nxt   = rm1;
            state_nxt = S_LEAD_CHK;
          end else begin
            idx_nxt = idx_m1;
          end
        end
      end
      S_LEAD_CHK: begin
        if (idx_r != '0 && !dsat_r[idx_r] && len_r >= down_r[idx_r]) begin
          if (c_r[idx_r] != '0) begin
            state_nxt = S_LEAD_DIV;
          end else begin
            idx_nxt = idx_m1;
          end
        end else begin
          state_nxt = S_FULL_CHK;
        end
      end
      S_LEAD_DIV: begin
        ar_op      = OP_DIV;
        ar_a       = len_r;
        ar_b       = down_r[idx_r];
        ar_start   = !issued_r;
        issued_nxt = 1'b1;
        if (ar_done) begin
          issued_nxt = 1'b0;
          sz_nxt     = (ar_quot < OFF_W'(room)) ? ar_quot : OFF_W'(room);
          phase_nxt  = PH_LEAD;
          state_nxt  = S_BS_MUL;
        end
      end
      S_BS_MUL: begin
        ar_op      = OP_MUL;
        ar_a       = sz_r;
        ar_b       = down_r[idx_r];
        ar_start   = !issued_r;
        issued_nxt = 1'b1;
        if (ar_done) begin
          issued_nxt = 1'b0;
          bs_nxt     = ar_acc;
          state_nxt  = S_EMIT;
        end
      end
      S_EMIT: begin
        // The held block goes out first; only then is it known not to be last.
        if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_blk_nxt   = pend_r;
            out_last_nxt  = 1'b0;
          end
          pend_valid_nxt = 1'b1;
          pend_nxt       = blk_w;
          state_nxt      = (phase_r == PH_FINAL) ? S_FLUSH : S_OFF_MUL;
        end
      end
      S_OFF_MUL: begin
        ar_op      = OP_MUL;
        ar_a       = bs_r;
        ar_b       = OFF_W'(eb_eff);
        ar_start   = !issued_r;
        issued_nxt = 1'b1;
        if (ar_done) begin
          issued_nxt = 1'b0;
          boff_nxt   = boff_r + ar_acc;
          len_nxt    = len_r - bs_r;
          unique case (phase_r)
            PH_LEAD: begin
              c_nxt[idx_r]  = '0;
              c_nxt[idx_m1] = c_r[idx_m1] + OFF_W'(1);
              state_nxt     = S_CARRY;
            end
            PH_FULL: begin
              c_nxt[0]  = c_r[0] + sz_r;
              idx_nxt   = IDX_W'(1);
              state_nxt = S_TRAIL_CHK;
            end
            PH_TRAIL: begin
              c_nxt[idx_r] = sz_r;
              idx_nxt      = idx_p1;
              state_nxt    = S_TRAIL_CHK;
            end
            PH_FINAL: begin
              state_nxt = S_FLUSH;
            end
          endcase
        end
      end
      S_CARRY: begin
        // One carry step per cycle; a coordinate that reaches its extent
        // wraps to zero and bumps the next slower one.
        if (idx_r != '0 && c_r[idx_m1] == OFF_W'(dims_eff[idx_m1])) begin
          c_nxt[idx_m1] = '0;
          if (idx_m1 != '0) begin
            c_nxt[idx_m2] = c_r[idx_m2] + OFF_W'(1);
          end
          idx_nxt = idx_m1;
        end else if (idx_r == '0) begin
          state_nxt = S_FULL_CHK;
        end else begin
          idx_nxt   = idx_m1;
          state_nxt = S_LEAD_CHK;
        end
      end
      S_FULL_CHK: begin
        if (!dsat_r[0] && len_r >= down_r[0]) begin
          idx_nxt   = '0;
          state_nxt = S_FULL_DIV;
        end else begin
          idx_nxt   = IDX_W'(1);
          state_nxt = S_TRAIL_CHK;
        end
      end
      S_FULL_DIV: begin
        ar_op      = OP_DIV;
        ar_a       = len_r;
        ar_b       = down_r[0];
        ar_start   = !issued_r;
        issued_nxt = 1'b1;
        if (ar_done) begin
          issued_nxt = 1'b0;
          sz_nxt     = (ar_quot < OFF_W'(dims_eff[0])) ? ar_quot : OFF_W'(dims_eff[0]);
          phase_nxt  = PH_FULL;
          state_nxt  = S_BS_MUL;
        end
      end
      S_TRAIL_CHK: begin
        if (len_r == '0) begin
          state_nxt = S_FLUSH;
        end else if (RANK_W'(idx_r) + RANK_W'(1) < r_eff) begin
          if (!dsat_r[idx_r] && len_r >= down_r[idx_r]) begin
            state_nxt = S_TRAIL_DIV;
          end else begin
            idx_nxt = idx_p1;
          end
        end else begin
          state_nxt = S_FINAL;
        end
      end
      S_TRAIL_DIV: begin
        ar_op      = OP_DIV;
        ar_a       = len_r;
        ar_b       = down_r[idx_r];
        ar_start   = !issued_r;
        issued_nxt = 1'b1;
        if (ar_done) begin
          issued_nxt = 1'b0;
          sz_nxt     = ar_quot;
          phase_nxt  = PH_TRAIL;
          state_nxt  = S_BS_MUL;
        end
      end
      S_FINAL: begin
        // Remaining elements form one row piece in the fastest dimension.
        sz_nxt    = len_r;
        idx_nxt   = rm1;
        phase_nxt = PH_FINAL;
        state_nxt = S_EMIT;
      end
      S_FLUSH: begin
        if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_valid_nxt  = 1'b1;
            out_blk_nxt    = pend_r;
            out_last_nxt   = 1'b1;
            pend_valid_nxt = 1'b0;
          end
          run_off_nxt = lastseq_r ? '0 : run_off_r + blen_r;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= PH_LEAD;
      idx_r        <= '0;
      issued_r     <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      run_off_r    <= '0;
      rank_r       <= RANK_W'(1);
      eb_r         <= EB_W'(1);
      for (int j = 0; j < NDIM; j++) begin
        dim_r[j] <= CRD_W'(1);
      end
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      idx_r        <= idx_nxt;
      issued_r     <= issued_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      run_off_r    <= run_off_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_RANK) begin
          rank_r <= cfg_wdata[RANK_W-1:0];
        end
        if (cfg_index == CFG_ELEM) begin
          eb_r <= cfg_wdata[EB_W-1:0];
        end
        for (int j = 0; j < NDIM; j++) begin
          if (cfg_index == CFG_DIM0 + CFG_IDX_W'(j)) begin
            dim_r[j] <= cfg_wdata;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    off_in_r   <= off_in_nxt;
    blen_r     <= blen_nxt;
    lastseq_r  <= lastseq_nxt;
    len_r      <= len_nxt;
    addr_r     <= addr_nxt;
    sz_r       <= sz_nxt;
    bs_r       <= bs_nxt;
    boff_r     <= boff_nxt;
    down_r     <= down_nxt;
    dsat_r     <= dsat_nxt;
    c_r        <= c_nxt;
    pend_r     <= pend_nxt;
    out_blk_r  <= out_blk_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_start_0       = out_blk_r.start[0];
  assign out_start_1       = out_blk_r.start[1];
  assign out_start_2       = out_blk_r.start[2];
  assign out_start_3       = out_blk_r.start[3];
  assign out_size_0        = out_blk_r.size[0];
  assign out_size_1        = out_blk_r.size[1];
  assign out_size_2        = out_blk_r.size[2];
  assign out_size_3        = out_blk_r.size[3];
  assign out_buffer_offset = out_blk_r.off;
  assign out_last_piece    = out_last_r;

  `LRHS_ASSERT_SAME(a_idle_no_pending, in_ready, !pend_valid_r)
  `LRHS_ASSERT_SAME(a_done_was_issued, ar_done, issued_r)
  `LRHS_ASSERT_NEXT(a_accept_goes_busy, in_valid && in_ready, !in_ready)

endmodule
